// File: hw/rtl/double_ended_queue_unit_assert.svh
// Assertion macros shared by the queue checker.
// No dependencies; included by name where assertions are written.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DEQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/deq_pkg.sv
// Shared types and codes for the double-ended queue.
// No dependencies; imported by the interfaces, the cell, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

   localparam int WORD_W   = 32;
   localparam int OPCODE_W = 2;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 5;

   localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   localparam logic [WORD_W-1:0] NO_VALUE = '1;

   // Command broadcast to every cell in a cycle.
   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_PUSH_BACK,
      CMD_PUSH_FRONT,
      CMD_POP_FRONT,
      CMD_POP_BACK
   } cmd_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [WORD_W-1:0] value;
   } cell_ctl_type;

   // What a cell shows its neighbors.
   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] data;
   } slot_type;

endpackage

`default_nettype wire

// File: hw/rtl/deq_ifs.sv
// Valid/ready channel interfaces for queue requests and responses.
// Depends on deq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface deq_req_if;
   import deq_pkg::*;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic signed [WORD_W-1:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface deq_rsp_if;
   import deq_pkg::*;
   logic                valid;
   logic                ready;
   logic signed [WORD_W-1:0] popped_value;
   logic [STATUS_W-1:0] status;
   logic [FILL_W-1:0]   fill_count;

   modport source (output valid, output popped_value, output status, output fill_count,
                   input ready);
   modport sink   (input valid, input popped_value, input status, input fill_count,
                   output ready);
endinterface

`default_nettype wire

// File: hw/rtl/double_ended_queue_unit.sv
// Double-ended queue top level: a row of shifting cells plus response register.
// Depends on deq_pkg, deq_ifs and deq_cell.
//
// Usage:
//  - req_chan carries one request: opcode (0 push back, 1 push front,
//    2 pop front, 3 pop back) and value (used by pushes only).
//  - rsp_chan returns exactly one response per request: popped_value
//    (removed value, or all ones), status (0 done, 1 pop on empty,
//    2 push on full) and fill_count (entries after the request, low 5 bits).
//  - Storage is a chain of DEPTH cells, front at cell 0. Front operations
//    shift the whole chain one place; back operations touch only the cell
//    at the end of the filled run, found locally by each cell.
//  - Response: registered, valid in the cycle after acceptance.
//  - Throughput: one request per cycle while responses are taken; all cells update in the same cycle.
//  - Stall: the response register frees as it is taken, so a new request is
//    accepted in the same cycle the old response leaves. While the response
//    sits untaken, req_chan.ready is low and the queue holds still.
//  - Reset: synchronous; all cells marked empty, no response pending.
//    Cell data is not cleared, and no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_unit #(
   parameter int DEPTH = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   deq_req_if.sink    req_chan,
   deq_rsp_if.source  rsp_chan
);
   import deq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   // chain[i] is the left neighbor of cell i; chain[i+1] is cell i itself
   slot_type          chain [DEPTH+1];
   logic [WORD_W-1:0] tail_word [DEPTH];
   logic [WORD_W-1:0] back_word;
   cell_ctl_type      ctl;

   logic              accept;
   logic              is_full, is_empty;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W+FILL_W-1:0] count_ext;

   logic              rsp_valid_ff;
   logic [WORD_W-1:0] popped_ff, popped_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   // left edge: a valid slot carrying the request value
   assign chain[0] = '{valid: 1'b1, data: req_chan.value};

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         slot_type right_nb;
         if (gi == DEPTH - 1) begin : g_last
            assign right_nb = '0;
         end else begin : g_mid
            assign right_nb = chain[gi+2];
         end
         deq_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .left      (chain[gi]),
            .right     (right_nb),
            .slot      (chain[gi+1]),
            .tail_data (tail_word[gi])
         );
      end
   endgenerate

   // only the last filled cell drives its data word; all other cells drive zero
   always_comb begin
      back_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_word = back_word | tail_word[i];
      end
   end

   // decode request into a cell command plus response fields
   always_comb begin
      ctl.cmd   = CMD_HOLD;
      ctl.value = req_chan.value;
      count_in  = count_ff;
      popped_in = NO_VALUE;
      status_in = ST_DONE;
      if (accept) begin
         unique case (req_chan.opcode)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  ctl.cmd  = (req_chan.opcode == OP_PUSH_BACK) ? CMD_PUSH_BACK
                                                              : CMD_PUSH_FRONT;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
               if (is_empty) begin
                  status_in = ST_EMPTY;
               end else if (req_chan.opcode == OP_POP_FRONT) begin
                  ctl.cmd   = CMD_POP_FRONT;
                  popped_in = chain[1].data;
                  count_in  = count_ff - CNT_W'(1);
               end else begin
                  ctl.cmd   = CMD_POP_BACK;
                  popped_in = back_word;
                  count_in  = count_ff - CNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign count_ext = {{FILL_W{1'b0}}, count_in};
   assign fill_in   = count_ext[FILL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         popped_ff <= popped_in;
         status_ff <= status_in;
         fill_ff   <= fill_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.popped_value = popped_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.fill_count   = fill_ff;

endmodule

`default_nettype wire

// File: hw/rtl/deq_cell.sv
// One storage cell of the queue chain: holds a slot, shifts with neighbors.
// Depends on deq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module deq_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire deq_pkg::cell_ctl_type     ctl,
   input  wire deq_pkg::slot_type         left,
   input  wire deq_pkg::slot_type         right,
   output deq_pkg::slot_type              slot,
   output logic [deq_pkg::WORD_W-1:0]     tail_data
);
   import deq_pkg::*;

   logic              valid_ff, valid_in;
   logic [WORD_W-1:0] data_ff, data_in;
   logic              is_tail;

   assign is_tail   = valid_ff && !right.valid;
   assign slot      = '{valid: valid_ff, data: data_ff};
   assign tail_data = is_tail ? data_ff : '0;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      unique case (ctl.cmd)
         CMD_PUSH_FRONT: begin
            valid_in = left.valid;
            data_in  = left.data;
         end
         CMD_POP_FRONT: begin
            valid_in = right.valid;
            data_in  = right.data;
         end
         CMD_PUSH_BACK: begin
            // first empty cell takes the value
            if (!valid_ff && left.valid) begin
               valid_in = 1'b1;
               data_in  = ctl.value;
            end
         end
         CMD_POP_BACK: begin
            if (is_tail) begin
               valid_in = 1'b0;
            end
         end
         CMD_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/deq_checker.sv
// Port-level checker for the double-ended queue, bound to the top level.
// Depends on deq_pkg and double_ended_queue_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "double_ended_queue_unit_assert.svh"

module deq_checker #(
   parameter int DEPTH = 16
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [deq_pkg::WORD_W-1:0]      rsp_popped_value,
   input wire logic [deq_pkg::STATUS_W-1:0]    rsp_status,
   input wire logic [deq_pkg::FILL_W-1:0]      rsp_fill_count
);
   import deq_pkg::*;

   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

   `DEQ_ASSERT_NEXT(a_req_gives_rsp, clock, reset, req_valid && req_ready,
      rsp_valid, "accepted request produced no response")

   `DEQ_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_popped_value) && $stable(rsp_status),
      "stalled response changed")

   `DEQ_ASSERT_NOW(a_empty_fields, clock, reset, rsp_valid && rsp_status == ST_EMPTY,
      rsp_fill_count == '0 && rsp_popped_value == NO_VALUE,
      "empty status with bad fields")

   `DEQ_ASSERT_NOW(a_full_fields, clock, reset, rsp_valid && rsp_status == ST_FULL,
      rsp_fill_count == FULL_FILL && rsp_popped_value == NO_VALUE,
      "full status with bad fields")

endmodule

bind double_ended_queue_unit deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_popped_value (rsp_chan.popped_value),
   .rsp_status       (rsp_chan.status),
   .rsp_fill_count   (rsp_chan.fill_count)
);

`default_nettype wire
